// File: src/lscc_pkg.sv
// shared types and constants of the limited-stock coin change core
`timescale 1ns / 1ps

package lscc_pkg;

    localparam int NUM_SLOTS = 8;
    localparam int SLOT_W    = 3;
    localparam int VALUE_W   = 12;
    localparam int AMOUNT_W  = 16;
    localparam int COINS_W   = 8;
    localparam int BIT_W     = $clog2(COINS_W);
    localparam int PROD_W    = COINS_W + VALUE_W;

    typedef logic [SLOT_W-1:0]   slot_t;
    typedef logic [VALUE_W-1:0]  value_t;
    typedef logic [AMOUNT_W-1:0] amount_t;
    typedef logic [COINS_W-1:0]  coins_t;
    typedef logic [PROD_W-1:0]   prod_t;

    typedef enum logic [0:0] {
        OP_CHANGE = 1'b0,
        OP_LOAD   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_FIT,
        ST_PAY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic   we;
        slot_t  addr;
        coins_t data;
    } mem_wr_t;

    typedef struct packed {
        logic   done;
        coins_t coins;
    } fit_status_t;

    function automatic value_t coin_value_reset(input int idx);
        value_t v;
        case (idx)
            0:       v = value_t'(200);
            1:       v = value_t'(100);
            2:       v = value_t'(50);
            3:       v = value_t'(20);
            4:       v = value_t'(10);
            5:       v = value_t'(5);
            6:       v = value_t'(2);
            default: v = value_t'(1);
        endcase
        return v;
    endfunction

endpackage

// File: src/lscc_stock_mem.sv
// coin stock memory with registered read and per-entry valid bits
`timescale 1ns / 1ps

module lscc_stock_mem
(
    input  logic              clk,
    input  logic              rst_n,
    input  lscc_pkg::mem_wr_t wr,
    input  logic              rd_en,
    input  lscc_pkg::slot_t   rd_addr,
    output lscc_pkg::coins_t  rd_data
);

    lscc_pkg::coins_t mem [lscc_pkg::NUM_SLOTS];
    logic [lscc_pkg::NUM_SLOTS-1:0] valid_reg;
    lscc_pkg::coins_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr.we)
        begin
            mem[wr.addr] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (wr.we)
        begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    // entries never written read as empty stock
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= valid_reg[rd_addr] ? mem[rd_addr] : '0;
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: src/lscc_fit.sv
// bit-serial search for the largest coin count within stock and remaining amount
`timescale 1ns / 1ps

module lscc_fit
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  lscc_pkg::coins_t      stock,
    input  lscc_pkg::value_t      coin_value,
    input  lscc_pkg::amount_t     remaining,
    output lscc_pkg::fit_status_t status
);

    logic                       busy_reg;
    logic [lscc_pkg::BIT_W-1:0] bit_reg;
    lscc_pkg::coins_t           count_reg;

    lscc_pkg::coins_t trial;
    lscc_pkg::prod_t  trial_prod;
    logic             fits;

    // one count bit per cycle, msb first
    assign trial      = count_reg | (lscc_pkg::coins_t'(1) << bit_reg);
    assign trial_prod = lscc_pkg::prod_t'(trial) * lscc_pkg::prod_t'(coin_value);
    assign fits       = (coin_value != '0) && (trial <= stock)
                      && (trial_prod <= lscc_pkg::prod_t'(remaining));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            bit_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            bit_reg  <= lscc_pkg::BIT_W'(lscc_pkg::COINS_W - 1);
        end
        else if (busy_reg)
        begin
            if (bit_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                bit_reg <= bit_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            count_reg <= '0;
        end
        else if (busy_reg && fits)
        begin
            count_reg <= trial;
        end
    end

    assign status.done  = busy_reg && (bit_reg == '0);
    assign status.coins = count_reg;

endmodule

// File: src/limited_stock_coin_change_core.sv
// top level of the limited-stock greedy coin change core
`timescale 1ns / 1ps

// A load word (tuser = 1) writes the stock count of one coin slot and gives one result word
// through the result and output registers. A change word (tuser = 0) walks the eight slots
// in order, slot 0 first (the largest coin with reset values), and gives one result word per
// slot, tlast on the eighth; the last word carries the short flag. Each slot steps through a
// stock memory read, the bit-serial count search (one count bit per cycle, one 8x12 multiply
// and compare), a payout that writes the stock back, and the hand-off of the word to the
// output register, which waits while the output side stalls. A new input word is taken only
// when the previous one is finished. The user must write coin values through the cfg port
// only while the core is idle; the core does not enforce this. Stock is empty after reset.

module limited_stock_coin_change_core
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // amount_cents[15:0], slot_select[18:16], stock_load[26:19]
    input  logic [0:0]  s_axis_tuser,   // op[0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // slot_out[2:0], coins_given[10:3], short_flag[11]
    output logic        m_axis_tlast,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    lscc_pkg::value_t  coin_value_reg [lscc_pkg::NUM_SLOTS];
    lscc_pkg::state_t  state_reg, state_next;
    lscc_pkg::slot_t   slot_reg, slot_next;
    lscc_pkg::amount_t rem_reg, rem_next;

    lscc_pkg::slot_t   res_slot_reg, res_slot_next;
    lscc_pkg::coins_t  res_coins_reg, res_coins_next;
    logic              res_short_reg, res_short_next;
    logic              res_last_reg, res_last_next;

    logic              out_valid_reg, out_valid_next;
    lscc_pkg::slot_t   out_slot_reg;
    lscc_pkg::coins_t  out_coins_reg;
    logic              out_short_reg;
    logic              out_last_reg;

    lscc_pkg::mem_wr_t     mem_wr;
    logic                  mem_rd_en;
    lscc_pkg::coins_t      stock_rd;
    lscc_pkg::fit_status_t fit_st;
    logic                  fit_start;

    lscc_pkg::value_t  cur_value;
    lscc_pkg::prod_t   paid;
    lscc_pkg::amount_t rem_after;
    logic              in_accept;
    logic              out_free;
    logic              slot_is_last;
    lscc_pkg::op_t     in_op;
    lscc_pkg::amount_t in_amount;
    lscc_pkg::slot_t   in_slot;
    lscc_pkg::coins_t  in_stock;

    assign in_op     = lscc_pkg::op_t'(s_axis_tuser[0]);
    assign in_amount = s_axis_tdata[15:0];
    assign in_slot   = s_axis_tdata[18:16];
    assign in_stock  = s_axis_tdata[26:19];

    assign s_axis_tready = (state_reg == lscc_pkg::ST_IDLE);
    assign in_accept     = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign slot_is_last  = (slot_reg == lscc_pkg::slot_t'(lscc_pkg::NUM_SLOTS - 1));

    assign cur_value = coin_value_reg[slot_reg];
    assign paid      = lscc_pkg::prod_t'(fit_st.coins) * lscc_pkg::prod_t'(cur_value);
    assign rem_after = rem_reg - paid[lscc_pkg::AMOUNT_W-1:0];

    // config registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < lscc_pkg::NUM_SLOTS; i++)
            begin
                coin_value_reg[i] <= lscc_pkg::coin_value_reset(i);
            end
        end
        else if (cfg_valid && cfg_ready && (int'(cfg_index) < lscc_pkg::NUM_SLOTS))
        begin
            coin_value_reg[cfg_index] <= cfg_data;
        end
    end

    lscc_stock_mem u_stock_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (mem_wr),
        .rd_en   (mem_rd_en),
        .rd_addr (slot_reg),
        .rd_data (stock_rd)
    );

    lscc_fit u_fit
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (fit_start),
        .stock      (stock_rd),
        .coin_value (cur_value),
        .remaining  (rem_reg),
        .status     (fit_st)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lscc_pkg::ST_IDLE;
            slot_reg      <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            slot_reg      <= slot_next;
            rem_reg       <= rem_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_slot_reg  <= res_slot_next;
        res_coins_reg <= res_coins_next;
        res_short_reg <= res_short_next;
        res_last_reg  <= res_last_next;
        if ((state_reg == lscc_pkg::ST_EMIT) && out_free)
        begin
            out_slot_reg  <= res_slot_reg;
            out_coins_reg <= res_coins_reg;
            out_short_reg <= res_short_reg;
            out_last_reg  <= res_last_reg;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        rem_next       = rem_reg;
        res_slot_next  = res_slot_reg;
        res_coins_next = res_coins_reg;
        res_short_next = res_short_reg;
        res_last_next  = res_last_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        mem_wr.we      = 1'b0;
        mem_wr.addr    = slot_reg;
        mem_wr.data    = stock_rd - fit_st.coins;
        mem_rd_en      = 1'b0;
        fit_start      = 1'b0;

        case (state_reg)
            lscc_pkg::ST_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_op == lscc_pkg::OP_LOAD)
                    begin
                        mem_wr.we      = (int'(in_slot) < lscc_pkg::NUM_SLOTS);
                        mem_wr.addr    = in_slot;
                        mem_wr.data    = in_stock;
                        res_slot_next  = in_slot;
                        res_coins_next = '0;
                        res_short_next = 1'b0;
                        res_last_next  = 1'b1;
                        state_next     = lscc_pkg::ST_EMIT;
                    end
                    else
                    begin
                        rem_next   = in_amount;
                        slot_next  = '0;
                        state_next = lscc_pkg::ST_READ;
                    end
                end
            end
            lscc_pkg::ST_READ:
            begin
                mem_rd_en  = 1'b1;
                fit_start  = 1'b1;
                state_next = lscc_pkg::ST_FIT;
            end
            lscc_pkg::ST_FIT:
            begin
                if (fit_st.done)
                begin
                    state_next = lscc_pkg::ST_PAY;
                end
            end
            lscc_pkg::ST_PAY:
            begin
                mem_wr.we      = 1'b1;
                rem_next       = rem_after;
                res_slot_next  = slot_reg;
                res_coins_next = fit_st.coins;
                res_short_next = slot_is_last && (rem_after != '0);
                res_last_next  = slot_is_last;
                state_next     = lscc_pkg::ST_EMIT;
            end
            lscc_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    if (res_last_reg)
                    begin
                        state_next = lscc_pkg::ST_IDLE;
                    end
                    else
                    begin
                        slot_next  = slot_reg + 1'b1;
                        state_next = lscc_pkg::ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = lscc_pkg::ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {4'b0, out_short_reg, out_coins_reg, out_slot_reg};
    assign m_axis_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    a_fit_done_in_fit: assert property (@(posedge clk) disable iff (!rst_n)
        fit_st.done |-> (state_reg == lscc_pkg::ST_FIT))
        else $error("count search finished outside its state");

    a_pay_within_stock: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lscc_pkg::ST_PAY) |-> (fit_st.coins <= stock_rd))
        else $error("coins paid exceed stock");

    a_rem_not_growing: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == lscc_pkg::ST_PAY) |=> (rem_reg <= $past(rem_reg)))
        else $error("remaining amount grew on payout");

    a_short_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[11]) |-> m_axis_tlast)
        else $error("short flag on a word that is not last");
`endif

endmodule
